### hdl/abe_pkg.sv
package abe_pkg;

    // Q1.16 weights: 1.0 is 2^16.
    localparam int unsigned Q_BITS = 16;
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;
    localparam logic [15:0] ROUND_Q16 = 16'hFFFF;

    // Output height saturates at the 16-bit field limit.
    localparam logic [15:0] OUT_MAX = 16'hFFFF;

    // Stream payload widths.
    localparam int unsigned IN_FIELD_W = 17;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    // Configuration port.
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ALT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ALT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd3;

    // The ratio divider produces one quotient bit per step.
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_W = $clog2(DIV_STEPS);

    // Product sequence of the shared multiplier. Chunk products of the
    // EMA step all use OP_CHUNK and follow the four weight products.
    localparam int unsigned OP_W = 3;
    typedef enum logic [OP_W-1:0] {
        OP_BLEND_ALT = 3'd0,
        OP_BLEND_GPS = 3'd1,
        OP_ALPHA_LO  = 3'd2,
        OP_ALPHA_HI  = 3'd3,
        OP_CHUNK     = 3'd4
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    seed;
        logic    ratio;
        logic    div_step;
        logic    mul;
        logic    acc;
        logic    target;
        logic    diff;
        logic    update;
        logic    out_load;
        t_mul_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic seed_now;
        logic need_div;
    } t_dp_sts;

endpackage

### hdl/abe_ctrl.sv
module abe_ctrl
    import abe_pkg::*;
#(
    parameter int unsigned NUM_CHUNKS = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int unsigned STEP_W = $clog2(int'(OP_CHUNK) + NUM_CHUNKS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(int'(OP_CHUNK) + NUM_CHUNKS - 1);
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIV_STEPS - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RATIO  = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_MUL    = 9'b000001000,
        S_ACC    = 9'b000010000,
        S_TARGET = 9'b000100000,
        S_DIFF   = 9'b001000000,
        S_UPDATE = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DIV_W-1:0]  r_div, n_div;
    logic              r_m_valid, n_m_valid;
    t_mul_op           op_c;

    assign op_c = (r_step >= STEP_W'(int'(OP_CHUNK))) ? OP_CHUNK : t_mul_op'(OP_W'(r_step));

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_div     = r_div;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        o_cmd.op  = op_c;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RATIO;
                end
            end
            S_RATIO: begin
                if (i_sts.seed_now) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    o_cmd.ratio = 1'b1;
                    n_step      = '0;
                    n_div       = '0;
                    n_state     = i_sts.need_div ? S_DIV : S_MUL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div          = r_div + DIV_W'(1);
                if (r_div == DIV_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_step    = r_step + STEP_W'(1);
                case (op_c)
                    OP_BLEND_GPS: n_state = S_TARGET;
                    OP_ALPHA_HI:  n_state = S_DIFF;
                    OP_CHUNK:     n_state = (r_step == LAST_STEP) ? S_UPDATE : S_MUL;
                    default:      n_state = S_MUL;
                endcase
            end
            S_TARGET: begin
                o_cmd.target = 1'b1;
                n_state      = S_MUL;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MUL;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // Wait here only while the previous result is still unclaimed.
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_div     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_div     <= n_div;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

### hdl/abe_datapath.sv
module abe_datapath
    import abe_pkg::*;
#(
    parameter int unsigned HEIGHT_BITS   = 16,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    localparam int unsigned HB = HEIGHT_BITS;
    localparam int unsigned FB = FRACTION_BITS;
    localparam int unsigned EW = HB + FB;
    localparam int unsigned CW = (HB > 17) ? HB : 17;
    localparam int unsigned NC = (EW + CW - 1) / CW;
    localparam int unsigned DW = NC * CW;
    localparam int unsigned PW = CW + 17;
    localparam int unsigned AW = EW + 17;
    localparam int unsigned MW = (EW > 16 + FB) ? EW : 16 + FB;
    localparam logic [31:0] HMAX = (32'd1 << HB) - 32'd1;

    // Configuration.
    logic [15:0] r_low_alt, r_high_alt;
    logic [16:0] r_alpha_low, r_alpha_high;

    // Item and state.
    logic [HB-1:0] r_alt, r_gps;
    logic          r_alt_ok, r_gps_ok;
    logic [EW-1:0] r_est;
    logic          r_seeded;

    // Work registers.
    logic [16:0]   r_t;
    logic [15:0]   r_rem, r_dvd, r_den;
    logic [PW-1:0] r_prod;
    logic [AW-1:0] r_acc;
    logic [EW-1:0] r_tgt;
    logic [16:0]   r_alpha;
    logic [DW-1:0] r_diff;
    logic          r_dir;
    logic [15:0]   r_out_height;
    logic          r_out_seeded;

    logic [31:0]   alt_raw, gps_raw;
    logic [HB-1:0] alt_sat, gps_sat;
    logic [16:0]   al_c, ah_c, t_inv;
    logic [MW-1:0] e_ext, lo_ext, hi_ext, num;
    logic [MW+15:0] num_wide;
    logic [31:0]   dvd_c;
    logic          e_le_lo, e_ge_hi;
    logic [16:0]   trial;
    logic          trial_ge;
    logic [16:0]   mul_a;
    logic [CW-1:0] mul_b;
    logic [PW-1:0] prod_c;
    logic [AW-1:0] acc_c;
    logic [EW+16:0] blend_w;
    logic [EW-1:0] tgt_c, diff_c;
    logic [AW:0]   rnd_c;
    logic [31:0]   ip_ext;

    // Input readings: bit 16 set means invalid; valid values saturate.
    assign alt_raw = 32'(i_s_tdata[15:0]);
    assign gps_raw = 32'(i_s_tdata[IN_FIELD_W+15:IN_FIELD_W]);
    assign alt_sat = (alt_raw > HMAX) ? HMAX[HB-1:0] : alt_raw[HB-1:0];
    assign gps_sat = (gps_raw > HMAX) ? HMAX[HB-1:0] : gps_raw[HB-1:0];

    assign al_c  = (r_alpha_low > ONE_Q16) ? ONE_Q16 : r_alpha_low;
    assign ah_c  = (r_alpha_high > ONE_Q16) ? ONE_Q16 : r_alpha_high;
    assign t_inv = ONE_Q16 - r_t;

    // Ratio setup: clamp cases, else the scaled dividend for the divider.
    assign e_ext    = MW'(r_est);
    assign lo_ext   = MW'({r_low_alt, {FB{1'b0}}});
    assign hi_ext   = MW'({r_high_alt, {FB{1'b0}}});
    assign e_le_lo  = (e_ext <= lo_ext);
    assign e_ge_hi  = (e_ext >= hi_ext);
    assign num      = e_ext - lo_ext;
    assign num_wide = {num, 16'h0000};
    assign dvd_c    = num_wide[FB +: 32];

    assign o_sts.seed_now = !r_seeded && r_alt_ok;
    assign o_sts.need_div = !e_le_lo && !e_ge_hi;

    assign trial    = {r_rem, r_dvd[15]};
    assign trial_ge = (trial >= {1'b0, r_den});

    // Shared multiplier operands.
    always_comb begin
        case (i_cmd.op)
            OP_BLEND_ALT: begin
                mul_a = t_inv;
                mul_b = CW'(r_alt);
            end
            OP_BLEND_GPS: begin
                mul_a = r_t;
                mul_b = CW'(r_gps);
            end
            OP_ALPHA_LO: begin
                mul_a = t_inv;
                mul_b = CW'(al_c);
            end
            OP_ALPHA_HI: begin
                mul_a = r_t;
                mul_b = CW'(ah_c);
            end
            OP_CHUNK: begin
                mul_a = r_alpha;
                mul_b = r_diff[DW-1 -: CW];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        case (i_cmd.op)
            OP_BLEND_ALT, OP_ALPHA_LO: acc_c = AW'(r_prod);
            OP_BLEND_GPS, OP_ALPHA_HI: acc_c = r_acc + AW'(r_prod);
            // Chunks arrive most significant first.
            OP_CHUNK:                  acc_c = (r_acc << CW) + AW'(r_prod);
            default:                   acc_c = r_acc;
        endcase
    end

    // Blended target brought from Q.16 to the estimate's fraction width.
    assign blend_w = {r_acc[HB+16:0], {FB{1'b0}}};

    always_comb begin
        if (r_alt_ok && r_gps_ok) begin
            tgt_c = blend_w[EW+15:Q_BITS];
        end else if (r_alt_ok) begin
            tgt_c = {r_alt, {FB{1'b0}}};
        end else if (r_gps_ok) begin
            tgt_c = {r_gps, {FB{1'b0}}};
        end else begin
            tgt_c = r_est;
        end
    end

    assign diff_c = (r_tgt >= r_est) ? (r_tgt - r_est) : (r_est - r_tgt);
    // A step downward rounds its magnitude up so the result stays floored.
    assign rnd_c  = {1'b0, r_acc} + (AW + 1)'(ROUND_Q16);
    assign ip_ext = 32'(r_est[EW-1:FB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_alt    <= 16'd300;
            r_high_alt   <= 16'd1000;
            r_alpha_low  <= 17'd32768;
            r_alpha_high <= 17'd6554;
            r_est        <= '0;
            r_seeded     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_ALT:    r_low_alt    <= i_cfg_data[15:0];
                    CFG_HIGH_ALT:   r_high_alt   <= i_cfg_data[15:0];
                    CFG_ALPHA_LOW:  r_alpha_low  <= i_cfg_data;
                    CFG_ALPHA_HIGH: r_alpha_high <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.seed) begin
                r_est    <= {r_alt, {FB{1'b0}}};
                r_seeded <= 1'b1;
            end else if (i_cmd.update) begin
                if (r_dir) begin
                    r_est <= r_est + r_acc[EW+15:Q_BITS];
                end else begin
                    r_est <= r_est - rnd_c[EW+15:Q_BITS];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_alt    <= alt_sat;
            r_gps    <= gps_sat;
            r_alt_ok <= !i_s_tdata[16];
            r_gps_ok <= !i_s_tdata[IN_FIELD_W+16];
        end
        if (i_cmd.ratio) begin
            r_t   <= e_le_lo ? 17'd0 : (e_ge_hi ? ONE_Q16 : 17'd0);
            r_rem <= dvd_c[31:16];
            r_dvd <= dvd_c[15:0];
            r_den <= r_high_alt - r_low_alt;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? 16'(trial - {1'b0, r_den}) : trial[15:0];
            r_dvd <= {r_dvd[14:0], 1'b0};
            r_t   <= {r_t[15:0], trial_ge};
        end
        if (i_cmd.mul) begin
            r_prod <= prod_c;
        end
        if (i_cmd.acc) begin
            r_acc <= acc_c;
            if (i_cmd.op == OP_CHUNK) begin
                r_diff <= r_diff << CW;
            end
        end else if (i_cmd.diff) begin
            r_acc   <= '0;
            r_alpha <= r_acc[32:16];
            r_diff  <= DW'(diff_c);
            r_dir   <= (r_tgt >= r_est);
        end
        if (i_cmd.target) begin
            r_tgt <= tgt_c;
        end
        if (i_cmd.out_load) begin
            r_out_height <= (ip_ext > 32'(OUT_MAX)) ? OUT_MAX : ip_ext[15:0];
            r_out_seeded <= r_seeded;
        end
    end

    assign o_m_tdata = {{(M_TDATA_W - 17){1'b0}}, r_out_seeded, r_out_height};

endmodule

### hdl/altitude_blend_adaptive_ema_core.sv
// Flow: a seeding item goes from the ratio state straight to the output state; any
// other item runs the ratio setup, the weight products and the NC chunk products of
// the EMA step, NC being the number of multiplier-width chunks of the estimate (2 at
// the default widths), and the radix-2 divider when the ratio needs it. One item is
// worked on at a time; the input is ready again in the cycle after the result is
// loaded. A new result waits in the output state while the last is unclaimed.
// The single shared 17-bit multiplier computes every product.
// Reset (synchronous, active low) clears the estimate, the seeded flag and the
// handshake state, and restores the configuration registers to their defaults.
module altitude_blend_adaptive_ema_core
    import abe_pkg::*;
#(
    parameter int unsigned HEIGHT_BITS   = 16,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [16:0] altimeter_height, [33:17] gps_height, [39:34] zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [15:0] estimated_height, [16] is_seeded, [23:17] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned EW = HEIGHT_BITS + FRACTION_BITS;
    localparam int unsigned CW = (HEIGHT_BITS > 17) ? HEIGHT_BITS : 17;
    localparam int unsigned NC = (EW + CW - 1) / CW;

    t_dp_cmd cmd;
    t_dp_sts sts;

    abe_ctrl #(
        .NUM_CHUNKS(NC)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    abe_datapath #(
        .HEIGHT_BITS  (HEIGHT_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

### hdl/abe_checker.sv
module abe_checker
    import abe_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_TDATA_W-1:0]  o_m_tdata
);

    // One item is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item was still being processed");

    // The block leaves idle only by taking an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(i_s_tvalid))
        else $error("input ready dropped without an accepted item");

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind altitude_blend_adaptive_ema_core abe_checker u_abe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
